// ----- hw/rtl/cmux_pkg.sv -----
// Shared types, constants and the FCS step function for the CMUX frame receiver.
package cmux_pkg;

    // Byte codes of the basic-option framing
    localparam logic [7:0] FLAG_BYTE = 8'hF9;
    localparam logic [7:0] FCS_POLY  = 8'hE0;
    localparam logic [7:0] FCS_INIT  = 8'hFF;
    localparam logic [7:0] PF_MASK   = 8'h10;
    localparam logic [7:0] UIH_TYPE  = 8'hEF;

    // Field widths
    localparam int LEN_W  = 15;
    localparam int ADDR_W = 6;
    localparam int KIND_W = 3;
    localparam int TDATA_W = 40;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 15'd128;

    // Parser states
    typedef enum logic [3:0] {
        ST_SOF  = 4'd0,
        ST_RS0  = 4'd1,
        ST_RS1  = 4'd2,
        ST_RS2  = 4'd3,
        ST_RS3  = 4'd4,
        ST_ADDR = 4'd5,
        ST_CTRL = 4'd6,
        ST_LEN  = 4'd7,
        ST_LENC = 4'd8,
        ST_DATA = 4'd9,
        ST_FCS  = 4'd10,
        ST_EOF  = 4'd11,
        ST_OVR  = 4'd12
    } t_state;

    // Result kinds carried on tuser
    typedef enum logic [KIND_W-1:0] {
        K_PAYLOAD = 3'd0,
        K_GOOD    = 3'd1,
        K_FCSERR  = 3'd2,
        K_OVERRUN = 3'd3,
        K_BADEOF  = 3'd4,
        K_RESYNC  = 3'd5
    } t_kind;

    // One byte of the reflected CRC-8 used for the frame check sequence
    function automatic logic [7:0] fcs_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ FCS_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/cmux_frame_receiver.sv -----
// Receive-side deframer of the basic-option CMUX protocol, one byte per request.
// A result is registered and appears on the master side in the cycle after its input byte is taken.
// Throughput: one byte per cycle; the parser, FCS step and header capture all
// update in the cycle the byte is accepted. The input stalls only while a result
// sits in the output register and the consumer does not take it.
// Reset (synchronous, active low): parser hunts for the opening flag, FCS = 0xFF,
// header registers cleared, max_payload = 128, output register empty.
module cmux_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: max_payload
    input  logic        i_cfg_wr_en,
    input  logic [14:0] i_cfg_wr_data,
    // Slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // Master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] data_byte, [13:8] address, [14] cr_bit, [15] pf_bit,
    // [23:16] frame_type, [38:24] payload_len, [39] zero
    output logic [39:0] o_m_tdata,
    output logic [2:0]  o_m_tuser    // [2:0] kind
);

    // Parser and header state
    cmux_pkg::t_state r_state, n_state;
    logic [7:0]                    r_fcs, n_fcs;
    logic [cmux_pkg::LEN_W-1:0]    r_len, n_len;
    logic [cmux_pkg::LEN_W-1:0]    r_count, n_count;
    logic [7:0]                    r_type, n_type;
    logic [cmux_pkg::ADDR_W-1:0]   r_addr, n_addr;
    logic                          r_cr, n_cr;
    logic                          r_pf, n_pf;
    logic [cmux_pkg::LEN_W-1:0]    r_max_payload;

    // Output register
    logic                          r_out_valid;
    logic [cmux_pkg::TDATA_W-1:0]  r_out_data, n_out_data;
    cmux_pkg::t_kind               r_out_kind, n_out_kind;
    logic                          n_emit;

    logic                          accept;
    logic [7:0]                    rx;
    logic                          is_flag;
    logic [cmux_pkg::LEN_W-1:0]    count_inc;
    logic [cmux_pkg::LEN_W-1:0]    len_two;
    logic [7:0]                    fcs_in;

    assign rx        = i_s_tdata;
    assign is_flag   = (rx == cmux_pkg::FLAG_BYTE);
    assign count_inc = r_count + 15'd1;
    assign len_two   = r_len | {rx, 7'd0};
    assign fcs_in    = cmux_pkg::fcs_step(r_fcs, rx);

    // The output register frees up in the same cycle its result is taken
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    // Next parser state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cmux_pkg::ST_SOF:  n_state = is_flag ? cmux_pkg::ST_ADDR : cmux_pkg::ST_RS0;
            cmux_pkg::ST_RS0:  n_state = is_flag ? cmux_pkg::ST_RS1 : cmux_pkg::ST_RS0;
            cmux_pkg::ST_RS1:  n_state = is_flag ? cmux_pkg::ST_RS2 : cmux_pkg::ST_RS0;
            cmux_pkg::ST_RS2:  n_state = is_flag ? cmux_pkg::ST_RS3 : cmux_pkg::ST_RS0;
            cmux_pkg::ST_RS3:  n_state = is_flag ? cmux_pkg::ST_RS3 : cmux_pkg::ST_CTRL;
            cmux_pkg::ST_ADDR: n_state = cmux_pkg::ST_CTRL;
            cmux_pkg::ST_CTRL: n_state = cmux_pkg::ST_LEN;
            cmux_pkg::ST_LEN: begin
                if (!rx[0]) begin
                    n_state = cmux_pkg::ST_LENC;
                end else begin
                    n_state = (rx[7:1] == 7'd0) ? cmux_pkg::ST_FCS : cmux_pkg::ST_DATA;
                end
            end
            cmux_pkg::ST_LENC: begin
                n_state = (len_two == '0) ? cmux_pkg::ST_FCS : cmux_pkg::ST_DATA;
            end
            cmux_pkg::ST_DATA: begin
                if (count_inc == r_len) begin
                    n_state = cmux_pkg::ST_FCS;
                end else if (count_inc == r_max_payload) begin
                    n_state = cmux_pkg::ST_OVR;
                end
            end
            cmux_pkg::ST_FCS: begin
                n_state = (~r_fcs == rx) ? cmux_pkg::ST_EOF : cmux_pkg::ST_SOF;
            end
            cmux_pkg::ST_EOF:  n_state = cmux_pkg::ST_SOF;
            cmux_pkg::ST_OVR:  n_state = cmux_pkg::ST_SOF;
            default:           n_state = cmux_pkg::ST_SOF;
        endcase
    end

    // Header capture, FCS update and the result for this byte
    always_comb begin
        n_fcs      = r_fcs;
        n_len      = r_len;
        n_count    = r_count;
        n_type     = r_type;
        n_addr     = r_addr;
        n_cr       = r_cr;
        n_pf       = r_pf;
        n_emit     = 1'b0;
        n_out_kind = cmux_pkg::K_PAYLOAD;
        n_out_data = {1'b0, r_len, r_type, r_pf, r_cr, r_addr, 8'd0};
        unique case (r_state)
            cmux_pkg::ST_SOF: begin
                if (!is_flag) begin
                    n_emit     = 1'b1;
                    n_out_kind = cmux_pkg::K_RESYNC;
                    n_out_data = '0;
                end
            end
            cmux_pkg::ST_RS3, cmux_pkg::ST_ADDR: begin
                if (!is_flag || r_state == cmux_pkg::ST_ADDR) begin
                    n_count = '0;
                    n_fcs   = cmux_pkg::fcs_step(cmux_pkg::FCS_INIT, rx);
                    n_cr    = rx[1];
                    n_addr  = rx[7:2];
                end
            end
            cmux_pkg::ST_CTRL: begin
                n_fcs  = fcs_in;
                n_pf   = rx[4];
                n_type = rx & ~cmux_pkg::PF_MASK;
            end
            cmux_pkg::ST_LEN: begin
                n_fcs = fcs_in;
                n_len = {8'd0, rx[7:1]};
            end
            cmux_pkg::ST_LENC: begin
                n_fcs = fcs_in;
                n_len = len_two;
            end
            cmux_pkg::ST_DATA: begin
                if (r_type != cmux_pkg::UIH_TYPE) begin
                    n_fcs = fcs_in;
                end
                n_count    = count_inc;
                n_emit     = 1'b1;
                n_out_kind = cmux_pkg::K_PAYLOAD;
                n_out_data[7:0] = rx;
            end
            cmux_pkg::ST_FCS: begin
                if (~r_fcs != rx) begin
                    n_emit     = 1'b1;
                    n_out_kind = cmux_pkg::K_FCSERR;
                end
            end
            cmux_pkg::ST_EOF: begin
                n_emit     = 1'b1;
                n_out_kind = is_flag ? cmux_pkg::K_GOOD : cmux_pkg::K_BADEOF;
            end
            cmux_pkg::ST_OVR: begin
                n_emit     = 1'b1;
                n_out_kind = cmux_pkg::K_OVERRUN;
            end
            default: begin
                n_emit = 1'b0;
            end
        endcase
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= cmux_pkg::MAX_PAYLOAD_RST;
        end else if (i_cfg_wr_en) begin
            r_max_payload <= i_cfg_wr_data;
        end
    end

    // Parser state registers, updated on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmux_pkg::ST_SOF;
            r_fcs   <= cmux_pkg::FCS_INIT;
            r_len   <= '0;
            r_count <= '0;
            r_type  <= '0;
            r_addr  <= '0;
            r_cr    <= 1'b0;
            r_pf    <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
            r_fcs   <= n_fcs;
            r_len   <= n_len;
            r_count <= n_count;
            r_type  <= n_type;
            r_addr  <= n_addr;
            r_cr    <= n_cr;
            r_pf    <= n_pf;
        end
    end

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= n_emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_out_data <= n_out_data;
            r_out_kind <= n_out_kind;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;

    // A resync result carries no header
    a_resync_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == cmux_pkg::K_RESYNC) |-> (o_m_tdata == '0))
        else $error("resync result carries nonzero fields");

    // Only payload results carry a data byte
    a_status_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != cmux_pkg::K_PAYLOAD) |-> (o_m_tdata[7:0] == 8'd0))
        else $error("status result carries a data byte");

    // Inside the payload the count stays below the length field
    a_count_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmux_pkg::ST_DATA) |-> (r_count < r_len))
        else $error("payload count reached length inside payload state");

    // A pending result that is not taken blocks the input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while a result is stalled");

    // A payload result always comes from a byte taken in the payload state
    a_payload_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_state != cmux_pkg::ST_DATA) |=>
        !(o_m_tvalid && o_m_tuser == cmux_pkg::K_PAYLOAD))
        else $error("payload result outside the payload state");

endmodule
